>>> hdl/lcs_pkg.sv
// Package for the linear congruence solver.
// Holds the default value width; no dependencies.
package lcs_pkg;
  localparam int unsigned ValueWidth = 62;
endpackage

>>> hdl/lcs_divider.sv
// Restoring bit-serial divider for the linear congruence solver.
// One quotient bit per cycle; depends on lcs_pkg for the default width.
module lcs_divider #(
  parameter int unsigned W = lcs_pkg::ValueWidth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] dividend_i,
  input  logic [W-1:0] divisor_i,
  output logic         done_o,
  output logic [W-1:0] quot_o,
  output logic [W-1:0] rem_o
);
  localparam int unsigned CW = $clog2(W + 1);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  quot_q, dsr_q;
  logic [W:0]    rem_q;
  logic [W:0]    shifted;
  logic          fits;

  assign shifted = {rem_q[W-1:0], quot_q[W-1]};
  assign fits    = shifted >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
        quot_q <= dividend_i;
        dsr_q  <= divisor_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q  <= fits ? shifted - {1'b0, dsr_q} : shifted;
        quot_q <= {quot_q[W-2:0], fits};
        cnt_q  <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q[W-1:0];
endmodule

>>> hdl/linear_congruence_solver.sv
// Top level of the linear congruence solver: finds least x with a*x = b mod n.
// Uses lcs_divider for every quotient and remainder; depends on lcs_pkg.
//
// Usage:
//   s_axis carries one item: multiplier, target, modulus. m_axis returns
//   solution and a solvable flag. s_axis_tready is high only while the block
//   is idle; one item is worked on at a time.
//   Each item runs gcd(a,b), gcd(g,n), three exact divisions, a coprimality
//   gcd and the extended Euclidean loop, all on one shared restoring divider.
//   Each Euclid step also runs a shift-and-add modular multiply.
//   The result sits in an output register until m_axis_tready takes it; the
//   block takes no new item before that. Reset clears the sequencer and
//   drops any result not yet taken.
module linear_congruence_solver #(
  parameter int unsigned VALUE_WIDTH = lcs_pkg::ValueWidth
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // [W-1:0] multiplier, [2W-1:W] target, [3W-1:2W] modulus, zero padded
  input  logic [((3*VALUE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // [W-1:0] solution, zero padded
  output logic [((VALUE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // [0] solvable
  output logic                     m_axis_tuser
);
  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned OW = ((VALUE_WIDTH + 7) / 8) * 8;
  localparam int unsigned CW = $clog2(W + 2);

  typedef enum logic [4:0] {
    ST_IDLE, ST_G1, ST_G1W, ST_G2, ST_G2W, ST_DA, ST_DAW, ST_DB, ST_DBW,
    ST_DN, ST_DNW, ST_C, ST_CW, ST_I0, ST_I0W, ST_E, ST_EW, ST_M0, ST_M,
    ST_MUL, ST_MULW, ST_OUT
  } state_e;

  state_e        state_q;
  logic [W-1:0]  a_q, b_q, n_q, x_q, y_q;
  logic [W-1:0]  r0_q, r1_q, t0_q, t1_q, q_q;
  logic [W-1:0]  acc_q, mx_q, my_q;
  logic [CW-1:0] mc_q;
  logic          ret_q;
  logic [W-1:0]  sol_q;
  logic          ok_q;

  logic          div_start;
  logic [W-1:0]  div_a, div_b, div_q, div_r;
  logic          div_done;

  lcs_divider #(.W(W)) u_div (
    .clk_i, .rst_ni,
    .start_i   (div_start),
    .dividend_i(div_a),
    .divisor_i (div_b),
    .done_o    (div_done),
    .quot_o    (div_q),
    .rem_o     (div_r)
  );

  logic [W:0] acc_sum, mx_sum;
  assign acc_sum = {1'b0, acc_q} + {1'b0, mx_q};
  assign mx_sum  = {1'b0, mx_q} + {1'b0, mx_q};

  assign div_start = (state_q == ST_G1 || state_q == ST_G2 || state_q == ST_DA
                      || state_q == ST_DB || state_q == ST_DN || state_q == ST_C
                      || state_q == ST_I0 || state_q == ST_E
                      || state_q == ST_MUL) && (y_q != '0);
  assign div_a = x_q;
  assign div_b = y_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = OW'(sol_q);
  assign m_axis_tuser  = ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: if (s_axis_tvalid) begin
          a_q <= s_axis_tdata[W-1:0];
          b_q <= s_axis_tdata[2*W-1:W];
          n_q <= s_axis_tdata[3*W-1:2*W];
          x_q <= s_axis_tdata[W-1:0];
          y_q <= s_axis_tdata[2*W-1:W];
          sol_q <= '0;
          ok_q  <= 1'b0;
          state_q <= (s_axis_tdata[3*W-1:2*W] == '0) ? ST_OUT : ST_G1;
        end
        // gcd loops: x <- y, y <- x mod y until y is zero
        ST_G1: if (y_q == '0) begin
          x_q <= n_q; y_q <= x_q; state_q <= ST_G2;
        end else state_q <= ST_G1W;
        ST_G1W: if (div_done) begin
          x_q <= y_q; y_q <= div_r; state_q <= ST_G1;
        end
        ST_G2: if (y_q == '0) begin
          x_q <= a_q; y_q <= x_q; state_q <= ST_DA;
        end else state_q <= ST_G2W;
        ST_G2W: if (div_done) begin
          x_q <= y_q; y_q <= div_r; state_q <= ST_G2;
        end
        ST_DA: state_q <= ST_DAW;
        ST_DAW: if (div_done) begin
          a_q <= div_q; x_q <= b_q; state_q <= ST_DB;
        end
        ST_DB: state_q <= ST_DBW;
        ST_DBW: if (div_done) begin
          b_q <= div_q; x_q <= n_q; state_q <= ST_DN;
        end
        ST_DN: state_q <= ST_DNW;
        ST_DNW: if (div_done) begin
          n_q <= div_q; x_q <= a_q; y_q <= div_q; state_q <= ST_C;
        end
        ST_C: if (y_q == '0) begin
          if (x_q != W'(1)) state_q <= ST_OUT;
          else if (n_q == W'(1)) begin
            ok_q <= 1'b1; state_q <= ST_OUT;
          end else begin
            x_q <= a_q; y_q <= n_q; state_q <= ST_I0;
          end
        end else state_q <= ST_CW;
        ST_CW: if (div_done) begin
          x_q <= y_q; y_q <= div_r; state_q <= ST_C;
        end
        ST_I0: state_q <= ST_I0W;
        ST_I0W: if (div_done) begin
          r0_q <= n_q; r1_q <= div_r; t0_q <= '0; t1_q <= W'(1);
          x_q <= n_q; y_q <= div_r; state_q <= ST_E;
        end
        ST_E: if (r1_q == '0) begin
          mx_q <= t0_q; x_q <= b_q; y_q <= n_q; state_q <= ST_MUL;
        end else state_q <= ST_EW;
        ST_EW: if (div_done) begin
          q_q <= div_q; r0_q <= r1_q; r1_q <= div_r;
          state_q <= ST_M0;
        end
        // q < n here except first step where q may reach n; reduce by subtract
        ST_M0: begin
          mx_q <= (q_q >= n_q) ? q_q - n_q : q_q;
          my_q <= t1_q; acc_q <= '0; mc_q <= CW'(W);
          ret_q <= 1'b0; state_q <= ST_M;
        end
        ST_M: if (my_q == '0 || mc_q == '0) begin
          if (!ret_q) begin
            t0_q <= t1_q;
            t1_q <= (acc_q == '0) ? t0_q :
                    ((t0_q >= acc_q) ? t0_q - acc_q : t0_q + (n_q - acc_q));
            x_q <= r0_q; y_q <= r1_q; state_q <= ST_E;
          end else begin
            sol_q <= acc_q; ok_q <= 1'b1; state_q <= ST_OUT;
          end
        end else begin
          if (my_q[0])
            acc_q <= (acc_sum >= {1'b0, n_q}) ? W'(acc_sum - {1'b0, n_q})
                                              : acc_sum[W-1:0];
          mx_q <= (mx_sum >= {1'b0, n_q}) ? W'(mx_sum - {1'b0, n_q})
                                          : mx_sum[W-1:0];
          my_q <= my_q >> 1;
          mc_q <= mc_q - 1'b1;
        end
        ST_MUL: state_q <= ST_MULW;
        ST_MULW: if (div_done) begin
          my_q <= div_r; acc_q <= '0; mc_q <= CW'(W);
          ret_q <= 1'b1; state_q <= ST_M;
        end
        ST_OUT: if (m_axis_tready) state_q <= ST_IDLE;
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule
